// ----- src/utp_pkg.sv -----
// ----------------------------------------------------------------------------
// utp_pkg: shared definitions of the text pre-tokenizer
// Types, sizes and code point class tables used by the front, the queue and
// the back of the pre-tokenizer.
// ----------------------------------------------------------------------------
package utp_pkg;

    localparam int FBUF   = 4;
    localparam int FCNT_W = $clog2(FBUF + 1);
    localparam int QDEPTH = 4;
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int CP_W   = 21;

    localparam logic [CP_W-1:0] CP_REPL  = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;
    localparam logic [7:0]      BYTE_QUOTE = 8'h27;

    typedef enum logic [2:0] {
        PC_SPACE  = 3'd0,
        PC_LETTER = 3'd1,
        PC_NUMBER = 3'd2,
        PC_PUNCT  = 3'd3,
        PC_CONTR  = 3'd4
    } piece_class_t;

    typedef struct packed {
        logic [FBUF-1:0][7:0] bytes;
        logic [1:0]           len_m1;
        logic [CP_W-1:0]      cp;
        logic                 last;
    } utp_cp_t;

    typedef struct packed {
        logic [FBUF-1:0][7:0] bytes;
        logic [1:0]           len_m1;
        piece_class_t         cls;
        logic                 sp20;
        logic                 quote;
        logic                 t_stmd;
        logic                 t_rv;
        logic                 t_l;
        logic                 t_e;
        logic                 last;
    } utp_item_t;

    typedef struct packed {
        utp_item_t         item0;
        utp_item_t         item1;
        utp_item_t         item2;
        logic [QCNT_W-1:0] count;
    } utp_window_t;

    localparam logic [CP_W-1:0] NUM_RANGE [36][2] = '{
        '{21'h0030, 21'h0039}, '{21'h0660, 21'h0669}, '{21'h06F0, 21'h06F9},
        '{21'h07C0, 21'h07C9}, '{21'h0966, 21'h096F}, '{21'h09E6, 21'h09EF},
        '{21'h0A66, 21'h0A6F}, '{21'h0AE6, 21'h0AEF}, '{21'h0B66, 21'h0B6F},
        '{21'h0BE6, 21'h0BEF}, '{21'h0C66, 21'h0C6F}, '{21'h0CE6, 21'h0CEF},
        '{21'h0D66, 21'h0D6F}, '{21'h0DE6, 21'h0DEF}, '{21'h0E50, 21'h0E59},
        '{21'h0ED0, 21'h0ED9}, '{21'h0F20, 21'h0F29}, '{21'h1040, 21'h1049},
        '{21'h17E0, 21'h17E9}, '{21'h1810, 21'h1819}, '{21'h1946, 21'h194F},
        '{21'h19D0, 21'h19D9}, '{21'h1A80, 21'h1A89}, '{21'h1A90, 21'h1A99},
        '{21'h1B50, 21'h1B59}, '{21'h1BB0, 21'h1BB9}, '{21'h1C40, 21'h1C49},
        '{21'h1C50, 21'h1C59}, '{21'hA620, 21'hA629}, '{21'hA8D0, 21'hA8D9},
        '{21'hA900, 21'hA909}, '{21'hA9D0, 21'hA9D9}, '{21'hA9F0, 21'hA9F9},
        '{21'hAA50, 21'hAA59}, '{21'hABF0, 21'hABF9}, '{21'hFF10, 21'hFF19}
    };

    localparam logic [CP_W-1:0] PUNCT_RANGE [13][2] = '{
        '{21'h02000, 21'h0206F}, '{21'h020A0, 21'h020CF}, '{21'h02100, 21'h0214F},
        '{21'h02190, 21'h02BFF}, '{21'h02E00, 21'h02E7F}, '{21'h03001, 21'h0303F},
        '{21'h0FE10, 21'h0FE1F}, '{21'h0FE30, 21'h0FE6F}, '{21'h0FF01, 21'h0FF0F},
        '{21'h0FF1A, 21'h0FF20}, '{21'h0FF3B, 21'h0FF40}, '{21'h0FF5B, 21'h0FF65},
        '{21'h1F000, 21'h1FAFF}
    };

    localparam logic [CP_W-1:0] PUNCT_SINGLE [27] = '{
        21'h00A1, 21'h00A2, 21'h00A3, 21'h00A4, 21'h00A5, 21'h00A6, 21'h00A7,
        21'h00A9, 21'h00AB, 21'h00AC, 21'h00AE, 21'h00B0, 21'h00B1, 21'h00B6,
        21'h00B7, 21'h00BB, 21'h00BF, 21'h00D7, 21'h00F7, 21'h060C, 21'h061B,
        21'h061F, 21'h066A, 21'h066B, 21'h066C, 21'h066D, 21'h06D4
    };

    function automatic logic utp_is_space(input logic [CP_W-1:0] cp);
        return (cp == CP_SPACE) || (cp >= 21'h09 && cp <= 21'h0D) ||
               (cp == 21'h0085) || (cp == 21'h00A0) || (cp == 21'h1680) ||
               (cp >= 21'h2000 && cp <= 21'h200A) || (cp == 21'h2028) ||
               (cp == 21'h2029) || (cp == 21'h202F) || (cp == 21'h205F) ||
               (cp == 21'h3000);
    endfunction

    function automatic piece_class_t utp_class(input logic [CP_W-1:0] cp);
        logic num;
        logic pun;
        logic alnum;
        piece_class_t res;
        num = 1'b0;
        pun = 1'b0;
        for (int k = 0; k < 36; k++) begin
            if (cp >= NUM_RANGE[k][0] && cp <= NUM_RANGE[k][1]) num = 1'b1;
        end
        for (int k = 0; k < 13; k++) begin
            if (cp >= PUNCT_RANGE[k][0] && cp <= PUNCT_RANGE[k][1]) pun = 1'b1;
        end
        for (int k = 0; k < 27; k++) begin
            if (cp == PUNCT_SINGLE[k]) pun = 1'b1;
        end
        alnum = (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A);
        if (utp_is_space(cp)) res = PC_SPACE;
        else if (num) res = PC_NUMBER;
        else if (cp < 21'h80) res = alnum ? PC_LETTER : PC_PUNCT;
        else if (pun) res = PC_PUNCT;
        else res = PC_LETTER;
        return res;
    endfunction

    function automatic logic [7:0] utp_fold(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

endpackage

// ----- src/utp_in_if.sv -----
// ----------------------------------------------------------------------------
// utp_in_if: byte input channel
// Valid/ready channel that carries one text byte and its end-of-text mark.
// ----------------------------------------------------------------------------
interface utp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, in_byte, end_of_text, input ready);
    modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

// ----- src/utp_out_if.sv -----
// ----------------------------------------------------------------------------
// utp_out_if: tagged byte output channel
// Valid/ready channel that carries one text byte with its piece marks.
// ----------------------------------------------------------------------------
interface utp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       piece_end;
    logic [2:0] piece_class;
    logic       text_end;

    modport source (output valid, out_byte, piece_end, piece_class, text_end, input ready);
    modport sink (input valid, out_byte, piece_end, piece_class, text_end, output ready);
endinterface

// ----- src/utf8_text_pretokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_text_pretokenizer_unit: UTF-8 text pre-tokenizer
// Cuts a byte stream into pieces and returns each byte tagged with its piece
// class, piece end and text end.
// ----------------------------------------------------------------------------
// The unit takes one byte per cycle and returns every byte once, in order,
// one per cycle, so the sustained rate is one byte per cycle in both
// directions while out_ch.ready holds; the output register sets it. Outside
// a contraction, a byte comes out once the code point after it (up to two
// after a quote at a piece start) has been decoded. At the end of a text the
// input holds until the four-byte decode buffer is empty, and a cut-off
// multibyte sequence in it is decoded one byte at a time.
// ----------------------------------------------------------------------------
module utf8_text_pretokenizer_unit (
    input  logic      clk,
    input  logic      rst_n,
    utp_in_if.sink    in_ch,
    utp_out_if.source out_ch
);
    import utp_pkg::*;

    logic        push_valid;
    logic        push_ready;
    utp_item_t   push_item;
    logic        pop;
    utp_window_t window;

    utp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    utp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .window     (window)
    );

    utp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .window (window),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

// ----- src/utp_front.sv -----
// ----------------------------------------------------------------------------
// utp_front: UTF-8 decoder and classifier
// Collects bytes, decodes one code point per cycle unless the queue is full,
// registers it, and tags it with its class and contraction hints for the queue.
// ----------------------------------------------------------------------------
module utp_front (
    input  logic              clk,
    input  logic              rst_n,
    utp_in_if.sink            in_ch,
    input  logic              push_ready,
    output logic              push_valid,
    output utp_pkg::utp_item_t push_item
);
    import utp_pkg::*;

    logic [FBUF-1:0][7:0] fb_reg;
    logic [FBUF-1:0][7:0] fb_next;
    logic [FCNT_W-1:0]    fcnt_reg;
    logic [FCNT_W-1:0]    fcnt_next;
    logic                 ended_reg;
    logic                 ended_next;
    utp_cp_t              s1_reg;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;

    logic [FCNT_W-1:0]    need;
    logic                 bad_lead;
    logic                 dec_valid;
    logic [FCNT_W-1:0]    dec_len;
    logic [CP_W-1:0]      dec_cp;
    logic                 s1_adv;
    logic                 fire;
    logic [FCNT_W-1:0]    consumed;
    logic [FCNT_W-1:0]    cnt_after;
    logic                 in_ready;
    logic                 accept;
    logic [FCNT_W-1:0]    idx;
    logic [7:0]           b0;
    logic [7:0]           fold0;

    always_comb
    begin
        b0 = fb_reg[0];
        bad_lead = 1'b0;
        need = FCNT_W'(1);
        if (!b0[7]) need = FCNT_W'(1);
        else if (b0[7:5] == 3'b110) need = FCNT_W'(2);
        else if (b0[7:4] == 4'b1110) need = FCNT_W'(3);
        else if (b0[7:3] == 5'b11110) need = FCNT_W'(4);
        else bad_lead = 1'b1;

        dec_valid = (fcnt_reg != '0) && ((need <= fcnt_reg) || ended_reg);
        if (bad_lead || need > fcnt_reg) begin
            dec_len = FCNT_W'(1);
            dec_cp = b0[7] ? CP_REPL : {13'd0, b0};
        end
        else begin
            dec_len = need;
            unique case (need)
                FCNT_W'(2): dec_cp = {10'd0, b0[4:0], fb_reg[1][5:0]};
                FCNT_W'(3): dec_cp = {5'd0, b0[3:0], fb_reg[1][5:0], fb_reg[2][5:0]};
                FCNT_W'(4): dec_cp = {b0[2:0], fb_reg[1][5:0], fb_reg[2][5:0],
                                      fb_reg[3][5:0]};
                default:    dec_cp = {13'd0, b0};
            endcase
        end
    end

    assign s1_adv    = !s1_valid_reg || push_ready;
    assign fire      = dec_valid && s1_adv;
    assign consumed  = fire ? dec_len : '0;
    assign cnt_after = fcnt_reg - consumed;
    assign in_ready  = ended_reg ? (cnt_after == '0) : (cnt_after < FCNT_W'(FBUF));
    assign accept    = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < FBUF; i++) begin
            idx = FCNT_W'(i) + consumed;
            fb_next[i] = fb_reg[idx[1:0]];
        end
        if (accept) fb_next[cnt_after[1:0]] = in_ch.in_byte;
        fcnt_next = cnt_after + FCNT_W'(accept);
        if (accept) ended_next = in_ch.end_of_text;
        else if (cnt_after == '0) ended_next = 1'b0;
        else ended_next = ended_reg;
        s1_valid_next = s1_adv ? fire : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg     <= '0;
            ended_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            fcnt_reg     <= fcnt_next;
            ended_reg    <= ended_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fb_reg <= fb_next;
        if (fire)
        begin
            s1_reg.bytes  <= fb_reg;
            s1_reg.len_m1 <= 2'(dec_len - FCNT_W'(1));
            s1_reg.cp     <= dec_cp;
            s1_reg.last   <= ended_reg && (dec_len == fcnt_reg);
        end
    end

    // Contraction hints look at the raw lead byte, not the decoded value.
    always_comb
    begin
        fold0 = utp_fold(s1_reg.bytes[0]);
        push_item.bytes  = s1_reg.bytes;
        push_item.len_m1 = s1_reg.len_m1;
        push_item.cls    = utp_class(s1_reg.cp);
        push_item.sp20   = (s1_reg.cp == CP_SPACE);
        push_item.quote  = (s1_reg.bytes[0] == BYTE_QUOTE);
        push_item.t_stmd = (fold0 == 8'h73) || (fold0 == 8'h74) ||
                           (fold0 == 8'h6D) || (fold0 == 8'h64);
        push_item.t_rv   = (fold0 == 8'h72) || (fold0 == 8'h76);
        push_item.t_l    = (fold0 == 8'h6C);
        push_item.t_e    = (fold0 == 8'h65);
        push_item.last   = s1_reg.last;
    end

    assign push_valid = s1_valid_reg;

endmodule

// ----- src/utp_queue.sv -----
// ----------------------------------------------------------------------------
// utp_queue: code point queue
// Short shifting queue between decoder and piece logic; the head and the two
// entries behind it are visible to the piece logic.
// ----------------------------------------------------------------------------
module utp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  utp_pkg::utp_item_t  push_item,
    output logic                push_ready,
    input  logic                pop,
    output utp_pkg::utp_window_t window
);
    import utp_pkg::*;

    utp_item_t         q_reg [QDEPTH];
    utp_item_t         q_next [QDEPTH];
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic [QCNT_W-1:0] wr_pos;
    logic              push;

    assign push_ready = (cnt_reg < QCNT_W'(QDEPTH));
    assign push       = push_valid && push_ready;
    assign wr_pos     = cnt_reg - QCNT_W'(pop);

    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) q_next[i] = q_reg[i + 1];
            else q_next[i] = q_reg[i];
        end
        if (push) q_next[wr_pos[QIDX_W-1:0]] = push_item;
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign window.item0 = q_reg[0];
    assign window.item1 = q_reg[1];
    assign window.item2 = q_reg[2];
    assign window.count = cnt_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + QCNT_W'(1))
        else $error("queue count lost a transfer");

endmodule

// ----- src/utp_back.sv -----
// ----------------------------------------------------------------------------
// utp_back: piece boundary logic
// Decides class and piece end of each code point from the queue head and the
// code points behind it, and sends its bytes out one per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module utp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  utp_pkg::utp_window_t window,
    output logic                 pop,
    utp_out_if.source            out_ch
);
    import utp_pkg::*;

    logic         open_reg;
    logic         open_next;
    piece_class_t run_class_reg;
    piece_class_t run_class_next;
    logic [1:0]   contr_cnt_reg;
    logic [1:0]   contr_cnt_next;
    logic [1:0]   byte_idx_reg;
    logic [1:0]   byte_idx_next;
    logic         ov_reg;
    logic         ov_next;
    logic [7:0]   ob_reg;
    logic         oend_reg;
    piece_class_t ocls_reg;
    logic         otext_reg;

    utp_item_t    c;
    utp_item_t    n1;
    utp_item_t    n2;
    logic         v0;
    logic         v1;
    logic         v2;
    logic         q_need;
    logic         rvl;
    logic         m3;
    logic         q_ok;
    logic         q_match;
    logic         dec_ok;
    piece_class_t cls;
    piece_class_t rc;
    logic         cp_end;
    logic         out_free;
    logic         emit;
    logic         last_byte;

    assign c  = window.item0;
    assign n1 = window.item1;
    assign n2 = window.item2;
    assign v0 = window.count >= QCNT_W'(1);
    assign v1 = window.count >= QCNT_W'(2);
    assign v2 = window.count >= QCNT_W'(3);

    always_comb
    begin
        q_need  = !open_reg && c.quote && (contr_cnt_reg == 2'd0);
        rvl     = n1.t_rv || n1.t_l;
        m3      = v2 && ((n1.t_l && n2.t_l) || (n1.t_rv && n2.t_e));
        q_ok    = c.last || (v1 && (!rvl || n1.last || v2));
        q_match = !c.last && v1 && (n1.t_stmd || (rvl && !n1.last && m3));

        rc             = open_reg ? run_class_reg : c.cls;
        cls            = rc;
        cp_end         = c.last || (n1.cls != rc);
        open_next      = open_reg;
        run_class_next = run_class_reg;
        contr_cnt_next = contr_cnt_reg;
        dec_ok         = v0 && (c.last || v1);

        if (contr_cnt_reg != 2'd0)
        begin
            dec_ok         = v0;
            cls            = PC_CONTR;
            cp_end         = (contr_cnt_reg == 2'd1);
            contr_cnt_next = contr_cnt_reg - 2'd1;
            open_next      = 1'b0;
        end
        else if (q_need && q_match)
        begin
            dec_ok         = v0 && q_ok;
            cls            = PC_CONTR;
            cp_end         = 1'b0;
            contr_cnt_next = n1.t_stmd ? 2'd1 : 2'd2;
            open_next      = 1'b0;
        end
        else if (!open_reg && c.sp20 && !c.last && v1 && n1.cls != PC_SPACE)
        begin
            // A lone space takes the class of the run that follows it.
            cls            = n1.cls;
            cp_end         = 1'b0;
            open_next      = 1'b1;
            run_class_next = n1.cls;
        end
        else
        begin
            if (q_need) dec_ok = v0 && q_ok;
            open_next      = !cp_end;
            run_class_next = rc;
        end
    end

    assign out_free  = !ov_reg || out_ch.ready;
    assign emit      = dec_ok && out_free;
    assign last_byte = (byte_idx_reg == c.len_m1);
    assign pop       = emit && last_byte;

    always_comb
    begin
        ov_next       = emit ? 1'b1 : (out_ch.ready ? 1'b0 : ov_reg);
        byte_idx_next = byte_idx_reg;
        if (emit) byte_idx_next = last_byte ? 2'd0 : byte_idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            run_class_reg <= PC_SPACE;
            contr_cnt_reg <= 2'd0;
            byte_idx_reg  <= 2'd0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            ov_reg       <= ov_next;
            byte_idx_reg <= byte_idx_next;
            if (pop)
            begin
                open_reg      <= open_next;
                run_class_reg <= run_class_next;
                contr_cnt_reg <= contr_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ob_reg    <= c.bytes[byte_idx_reg];
            oend_reg  <= cp_end && last_byte;
            ocls_reg  <= cls;
            otext_reg <= c.last && last_byte;
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.out_byte    = ob_reg;
    assign out_ch.piece_end   = oend_reg;
    assign out_ch.piece_class = ocls_reg;
    assign out_ch.text_end    = otext_reg;

    a_contr_closed: assert property (@(posedge clk) disable iff (!rst_n)
        contr_cnt_reg != 2'd0 |-> !open_reg)
        else $error("contraction inside an open piece");
    a_text_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && c.last) |=> !open_reg && contr_cnt_reg == 2'd0)
        else $error("piece state left over after text end");
    a_text_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && c.last && last_byte) |=> out_ch.piece_end)
        else $error("last byte of text does not close its piece");

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the UTF-8 text pre-tokenizer
// Texts are fed one byte per transfer while a local predictor cuts them into
// pieces. Every tagged byte that comes back is checked in order against the
// predicted byte, piece end, piece class and text end. Both channels idle at
// random, and the output holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_top;
    import utp_pkg::*;

    typedef struct {
        logic [7:0]   b;
        logic         pe;
        piece_class_t cls;
        logic         te;
    } tagged_byte_t;

    logic clk;
    logic rst_n;

    utp_in_if  in_ch ();
    utp_out_if out_ch ();

    utf8_text_pretokenizer_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    localparam int unsigned DIGIT_SPAN [36][2] = '{
        '{'h0030, 'h0039}, '{'h0660, 'h0669}, '{'h06F0, 'h06F9}, '{'h07C0, 'h07C9},
        '{'h0966, 'h096F}, '{'h09E6, 'h09EF}, '{'h0A66, 'h0A6F}, '{'h0AE6, 'h0AEF},
        '{'h0B66, 'h0B6F}, '{'h0BE6, 'h0BEF}, '{'h0C66, 'h0C6F}, '{'h0CE6, 'h0CEF},
        '{'h0D66, 'h0D6F}, '{'h0DE6, 'h0DEF}, '{'h0E50, 'h0E59}, '{'h0ED0, 'h0ED9},
        '{'h0F20, 'h0F29}, '{'h1040, 'h1049}, '{'h17E0, 'h17E9}, '{'h1810, 'h1819},
        '{'h1946, 'h194F}, '{'h19D0, 'h19D9}, '{'h1A80, 'h1A89}, '{'h1A90, 'h1A99},
        '{'h1B50, 'h1B59}, '{'h1BB0, 'h1BB9}, '{'h1C40, 'h1C49}, '{'h1C50, 'h1C59},
        '{'hA620, 'hA629}, '{'hA8D0, 'hA8D9}, '{'hA900, 'hA909}, '{'hA9D0, 'hA9D9},
        '{'hA9F0, 'hA9F9}, '{'hAA50, 'hAA59}, '{'hABF0, 'hABF9}, '{'hFF10, 'hFF19}
    };
    localparam int unsigned SYMBOL_SPAN [13][2] = '{
        '{'h2000, 'h206F}, '{'h20A0, 'h20CF}, '{'h2100, 'h214F}, '{'h2190, 'h2BFF},
        '{'h2E00, 'h2E7F}, '{'h3001, 'h303F}, '{'hFE10, 'hFE1F}, '{'hFE30, 'hFE6F},
        '{'hFF01, 'hFF0F}, '{'hFF1A, 'hFF20}, '{'hFF3B, 'hFF40}, '{'hFF5B, 'hFF65},
        '{'h1F000, 'h1FAFF}
    };
    localparam int unsigned SYMBOL_ONE [27] = '{
        'h00A1, 'h00A2, 'h00A3, 'h00A4, 'h00A5, 'h00A6, 'h00A7, 'h00A9, 'h00AB,
        'h00AC, 'h00AE, 'h00B0, 'h00B1, 'h00B6, 'h00B7, 'h00BB, 'h00BF, 'h00D7,
        'h00F7, 'h060C, 'h061B, 'h061F, 'h066A, 'h066B, 'h066C, 'h066D, 'h06D4
    };
    localparam int unsigned SAMPLE_CP [12] = '{
        'h00E9, 'h0663, 'h2014, 'h3000, 'h00A0, 'h1F600, 'hFF11, 'h4E2D,
        'h2028, 'h00A9, 'h0085, 'h10348
    };

    logic [7:0]   held_bytes [8];
    int           held_count;
    piece_class_t cur_class;
    logic         in_piece;
    logic         space_waiting;
    logic         text_closing;

    tagged_byte_t expected_bytes [$];
    int           mismatches;
    int           checked_bytes;
    int           sent_bytes;
    int           texts_sent;
    int           hold_off_cycles;
    logic         out_busy;

    function automatic logic is_blank(int unsigned cp);
        return cp == 'h20 || (cp >= 'h09 && cp <= 'h0D) || cp == 'h0085 ||
               cp == 'h00A0 || cp == 'h1680 || (cp >= 'h2000 && cp <= 'h200A) ||
               cp == 'h2028 || cp == 'h2029 || cp == 'h202F || cp == 'h205F ||
               cp == 'h3000;
    endfunction

    function automatic piece_class_t class_of_cp(int unsigned cp);
        if (is_blank(cp))
            return PC_SPACE;
        foreach (DIGIT_SPAN[k])
            if (cp >= DIGIT_SPAN[k][0] && cp <= DIGIT_SPAN[k][1])
                return PC_NUMBER;
        if (cp < 'h80)
            return ((cp >= 'h41 && cp <= 'h5A) || (cp >= 'h61 && cp <= 'h7A)) ?
                   PC_LETTER : PC_PUNCT;
        foreach (SYMBOL_SPAN[k])
            if (cp >= SYMBOL_SPAN[k][0] && cp <= SYMBOL_SPAN[k][1])
                return PC_PUNCT;
        foreach (SYMBOL_ONE[k])
            if (cp == SYMBOL_ONE[k])
                return PC_PUNCT;
        return PC_LETTER;
    endfunction

    // Returns 0 when more bytes are needed, 1 on a code point, 2 past the text end.
    function automatic int decode_held(int pos, output int unsigned cp, output int len);
        int avail;
        int need;
        int unsigned lead;
        cp = 0;
        len = 1;
        avail = (held_count > pos) ? held_count - pos : 0;
        if (avail == 0)
            return text_closing ? 2 : 0;
        lead = held_bytes[pos];
        if (lead < 'h80)
        begin
            cp = lead;
            return 1;
        end
        if (lead[7:5] == 3'b110)
        begin
            need = 2;
            cp = lead & 'h1F;
        end
        else if (lead[7:4] == 4'b1110)
        begin
            need = 3;
            cp = lead & 'h0F;
        end
        else if (lead[7:3] == 5'b11110)
        begin
            need = 4;
            cp = lead & 'h07;
        end
        else
        begin
            cp = 'hFFFD;
            return 1;
        end
        if (avail < need)
        begin
            if (!text_closing)
                return 0;
            cp = 'hFFFD;
            return 1;
        end
        for (int k = 1; k < need; k++)
            cp = (cp << 6) | (held_bytes[pos + k] & 'h3F);
        len = need;
        return 1;
    endfunction

    function automatic logic [7:0] lower_ascii(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

    // Length of a contraction at the head: -1 undecided, 0 none.
    function automatic int contraction_len();
        logic [7:0] c1;
        logic [7:0] c2;
        if (held_count < 2)
            return text_closing ? 0 : -1;
        c1 = lower_ascii(held_bytes[1]);
        if (c1 == "s" || c1 == "t" || c1 == "m" || c1 == "d")
            return 2;
        if (c1 != "r" && c1 != "v" && c1 != "l")
            return 0;
        if (held_count < 3)
            return text_closing ? 0 : -1;
        c2 = lower_ascii(held_bytes[2]);
        if ((c1 == "l" && c2 == "l") || (c1 != "l" && c2 == "e"))
            return 3;
        return 0;
    endfunction

    function automatic void release_head(int cnt, logic closes, piece_class_t cls);
        tagged_byte_t t;
        if (cnt > held_count)
            cnt = held_count;
        for (int k = 0; k < cnt; k++)
        begin
            t.b = held_bytes[k];
            t.pe = closes && (k == cnt - 1);
            t.cls = cls;
            t.te = 1'b0;
            expected_bytes.push_back(t);
        end
        for (int k = 0; k + cnt < held_count; k++)
            held_bytes[k] = held_bytes[k + cnt];
        held_count -= cnt;
    endfunction

    function automatic void cut_pieces();
        int unsigned cp;
        int unsigned nx;
        int len;
        int nl;
        int r;
        int m;
        logic closes;
        while (held_count > 0)
        begin
            if (!in_piece)
            begin
                if (held_bytes[0] == BYTE_QUOTE)
                begin
                    m = contraction_len();
                    if (m < 0)
                        return;
                    if (m > 0)
                    begin
                        release_head(m, 1'b1, PC_CONTR);
                        continue;
                    end
                end
                if (decode_held(0, cp, len) != 1)
                    return;
                if (cp == 'h20)
                begin
                    r = decode_held(1, nx, nl);
                    if (r == 0)
                        return;
                    if (r == 1 && !is_blank(nx))
                    begin
                        cur_class = class_of_cp(nx);
                        space_waiting = 1'b1;
                        in_piece = 1'b1;
                        continue;
                    end
                end
                cur_class = class_of_cp(cp);
                in_piece = 1'b1;
                continue;
            end
            if (space_waiting)
            begin
                release_head(1, 1'b0, cur_class);
                space_waiting = 1'b0;
                continue;
            end
            if (decode_held(0, cp, len) != 1)
                return;
            r = decode_held(len, nx, nl);
            if (r == 0)
                return;
            closes = (r == 2) || (class_of_cp(nx) != cur_class);
            release_head(len, closes, cur_class);
            if (closes)
                in_piece = 1'b0;
        end
    endfunction

    function automatic void clear_predictor();
        held_count = 0;
        cur_class = PC_SPACE;
        in_piece = 1'b0;
        space_waiting = 1'b0;
        text_closing = 1'b0;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic eot);
        int before_n;
        before_n = expected_bytes.size();
        if (held_count < 8)
        begin
            held_bytes[held_count] = b;
            held_count++;
        end
        text_closing = eot;
        cut_pieces();
        if (eot)
        begin
            if (expected_bytes.size() > before_n)
                expected_bytes[$].te = 1'b1;
            clear_predictor();
        end
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #3000000;
        $display("utf8_text_pretokenizer_unit: mismatch");
        $finish;
    end

    // Output side: random stalls per transfer while out_busy, with a long hold-off on request.
    initial
    begin
        int w;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                w = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
                w = out_busy ? $urandom_range(0, 10) : 0;
            if (w > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        tagged_byte_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            checked_bytes++;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte %h at %0t", out_ch.out_byte, $realtime);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_ch.out_byte !== want.b || out_ch.piece_end !== want.pe ||
                    out_ch.piece_class !== want.cls || out_ch.text_end !== want.te)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("byte %0d: expected %h/%b/%0d/%b, got %h/%b/%0d/%b",
                                 checked_bytes, want.b, want.pe, want.cls, want.te,
                                 out_ch.out_byte, out_ch.piece_end,
                                 out_ch.piece_class, out_ch.text_end);
                end
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic eot, logic eager);
        int gap;
        gap = eager ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.end_of_text <= eot;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_byte(b, eot);
        sent_bytes++;
    endtask

    task automatic send_text(logic [7:0] text [$], logic eager = 1'b0);
        foreach (text[k])
            send_byte(text[k], k == text.size() - 1, eager);
        texts_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_bytes.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic void push_utf8(ref logic [7:0] text [$], input int unsigned cp);
        if (cp < 'h80)
            text.push_back(cp[7:0]);
        else if (cp < 'h800)
        begin
            text.push_back(8'hC0 | cp[10:6]);
            text.push_back(8'h80 | cp[5:0]);
        end
        else if (cp < 'h10000)
        begin
            text.push_back(8'hE0 | cp[15:12]);
            text.push_back(8'h80 | cp[11:6]);
            text.push_back(8'h80 | cp[5:0]);
        end
        else
        begin
            text.push_back(8'hF0 | cp[20:18]);
            text.push_back(8'h80 | cp[17:12]);
            text.push_back(8'h80 | cp[11:6]);
            text.push_back(8'h80 | cp[5:0]);
        end
    endfunction

    function automatic void push_token(ref logic [7:0] text [$]);
        logic [7:0] sfx [7] = '{"s", "t", "m", "d", "r", "v", "l"};
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 4))
                text.push_back(8'h61 + $urandom_range(0, 25) - ($urandom_range(0, 1) * 8'h20));
            2: repeat ($urandom_range(1, 3)) text.push_back(8'h30 + $urandom_range(0, 9));
            3: text.push_back(8'h20);
            4: repeat ($urandom_range(1, 3)) text.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
            5:
            begin
                text.push_back(BYTE_QUOTE);
                c = sfx[$urandom_range(0, 6)];
                text.push_back($urandom_range(0, 1) ? c - 8'h20 : c);
                if (c == "r" || c == "v") text.push_back("e");
                if (c == "l") text.push_back($urandom_range(0, 3) ? "l" : "x");
            end
            6, 7: push_utf8(text, SAMPLE_CP[$urandom_range(0, 11)]);
            8: text.push_back(8'h21 + $urandom_range(0, 14));
            default: text.push_back($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_contractions();
        send_text('{"i", "t", "'", "s"});
        send_text('{"'", "L", "L"});
        send_text('{"'", "x"});
    endtask

    task automatic test_space_joining();
        send_text('{" ", "a", "b", " ", "1"});
        send_text('{" ", 8'h09});
    endtask

    task automatic test_utf8_classes();
        send_text('{8'hC3, 8'hA9, "5", 8'hE2, 8'h80, 8'h94});
        send_text('{8'hF0, 8'h9F, 8'h98, 8'h80});
    endtask

    task automatic test_bad_and_truncated();
        send_text('{"a", 8'hE2});
        send_text('{8'hFF, 8'h80});
    endtask

    task automatic test_random_texts(int budget);
        logic [7:0] text [$];
        int start;
        start = sent_bytes;
        while (sent_bytes - start < budget)
        begin
            text.delete();
            repeat ($urandom_range(1, 6)) push_token(text);
            send_text(text, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                wait_idle();
        end
    endtask

    task automatic test_output_hold_off();
        logic [7:0] text [$];
        repeat (8) push_token(text);
        hold_off_cycles = 80;
        send_text(text, 1'b1);
        wait_idle();
    endtask

    initial
    begin
        mismatches = 0;
        checked_bytes = 0;
        sent_bytes = 0;
        texts_sent = 0;
        hold_off_cycles = 0;
        out_busy = 1'b1;
        clear_predictor();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.end_of_text = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_contractions();
        test_space_joining();
        test_utf8_classes();
        test_bad_and_truncated();
        wait_idle();
        test_output_hold_off();
        test_random_texts(60);
        out_busy = 1'b0;
        test_random_texts(30);
        out_busy = 1'b1;
        test_random_texts(40);
        wait_idle();
        $display("Sent %0d bytes in %0d texts; checked %0d tagged bytes.",
                 sent_bytes, texts_sent, checked_bytes);
        $display("Covered contractions, joined spaces, UTF-8 classes, bad lead bytes and stalls.");
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("utf8_text_pretokenizer_unit: match");
        else
            $display("utf8_text_pretokenizer_unit: mismatch");
        $finish;
    end
endmodule
